@@ sv/integer_to_ascii_digits_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef INTEGER_TO_ASCII_DIGITS_MACROS_SVH
`define INTEGER_TO_ASCII_DIGITS_MACROS_SVH

// Concurrent check on aclk, switched off while aresetn is low.
`define I2A_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Concurrent check on aclk that also runs during reset.
`define I2A_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ sv/i2a_pkg.sv @@
// Shared constants, control structs and the digit glyph function.
package i2a_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int DEC_DIGITS_DEF = 20;
    localparam int IN_W           = 64;
    localparam int OP_W           = 2;
    localparam int CHAR_W         = 7;
    localparam int DIGIT_W        = 4;

    localparam logic [OP_W-1:0] OP_UDEC = 2'd0;
    localparam logic [OP_W-1:0] OP_UHEX = 2'd1;
    localparam logic [OP_W-1:0] OP_SDEC = 2'd2;

    localparam logic [CHAR_W-1:0] ASCII_MINUS   = 7'h2D;
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;

    localparam logic [DIGIT_W-1:0] RADIX_DEC    = 4'd10;
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADJ   = 4'd3;

    // Control for the binary shift register
    typedef struct packed {
        logic load;
        logic negate;
        logic shift;
    } i2a_bin_ctrl_t;

    // Control for the digit register
    typedef struct packed {
        logic clear;
        logic bit_shift;
        logic hex;
        logic digit_shift;
    } i2a_bcd_ctrl_t;

    // Map a digit to its upper-case ASCII glyph
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < RADIX_DEC) begin
            return ASCII_ZERO + dx;
        end else begin
            return ASCII_UPPER_A + dx - {{(CHAR_W-DIGIT_W){1'b0}}, RADIX_DEC};
        end
    endfunction

endpackage

@@ sv/i2a_bin_sr.sv @@
// Binary shift register: serial two's complement negation and MSB-first shift-out.
module i2a_bin_sr import i2a_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  i2a_bin_ctrl_t         ctrl,
    input  logic [VALUE_BITS-1:0] load_value,
    output logic                  msb
);

    logic [VALUE_BITS-1:0] sr_reg, sr_next;
    logic                  carry_reg, carry_next;

    // Load, negate one bit LSB first by rotating right, or shift left
    always_comb begin
        sr_next    = sr_reg;
        carry_next = carry_reg;
        if (ctrl.load) begin
            sr_next    = load_value;
            carry_next = 1'b1;
        end else if (ctrl.negate) begin
            sr_next    = {(~sr_reg[0]) ^ carry_reg, sr_reg[VALUE_BITS-1:1]};
            carry_next = (~sr_reg[0]) & carry_reg;
        end else if (ctrl.shift) begin
            sr_next    = {sr_reg[VALUE_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        sr_reg    <= sr_next;
        carry_reg <= carry_next;
    end

    assign msb = sr_reg[VALUE_BITS-1];

endmodule

@@ sv/i2a_bcd.sv @@
// Digit register: shift-and-add-3 conversion one bit a cycle (plain shift in hex mode), then digit shift-out.
module i2a_bcd import i2a_pkg::*; #(
    parameter int DIGITS = DEC_DIGITS_DEF
) (
    input  logic               aclk,
    input  i2a_bcd_ctrl_t      ctrl,
    input  logic               bit_in,
    output logic [DIGIT_W-1:0] top_digit
);

    localparam int W = DIGITS * DIGIT_W;

    logic [W-1:0] dig_reg, dig_next;
    logic [W-1:0] corr;

    // In decimal mode, add three to every digit of five or more before the shift
    always_comb begin
        logic [DIGIT_W-1:0] d;
        d = '0;
        for (int i = 0; i < DIGITS; i++) begin
            d = dig_reg[i*DIGIT_W +: DIGIT_W];
            if (!ctrl.hex && d >= DABBLE_LIMIT) begin
                corr[i*DIGIT_W +: DIGIT_W] = d + DABBLE_ADJ;
            end else begin
                corr[i*DIGIT_W +: DIGIT_W] = d;
            end
        end
    end

    // Clear, take one bit, or drop the top digit
    always_comb begin
        dig_next = dig_reg;
        if (ctrl.clear) begin
            dig_next = '0;
        end else if (ctrl.bit_shift) begin
            dig_next = {corr[W-2:0], bit_in};
        end else if (ctrl.digit_shift) begin
            dig_next = {dig_reg[W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        dig_reg <= dig_next;
    end

    assign top_digit = dig_reg[W-1 -: DIGIT_W];

endmodule

@@ sv/integer_to_ascii_digits.sv @@
// Top level: integer to ASCII digit string converter with sequencer and output register.
//
// Input channel s_*: one beat carries s_value and s_op (0 unsigned decimal,
// 1 unsigned upper-case hex, 2 signed decimal, 3 as 0). Only the low
// VALUE_BITS bits of s_value count. Output channel m_*: one beat per
// character, most significant digit first, m_last high on the final one.
// A negative signed value gives '-' first; zero gives a single '0'.
// Throughput: one number at a time. After the input beat the value is
// shifted bit-serially through a shift-and-add-3 digit register (a plain
// shift for hex), all VALUE_BITS bits (64 by default); a negative signed
// value is first negated bit-serially. Then the digit register is walked
// once, one digit a cycle while the receiver does not stall (20 digits at
// 64 bits): leading zeros are dropped, then a '-' goes out if the value was
// negative, then the remaining digits. The first character is registered
// once the leading zeros have been dropped.
// s_ready is high whenever no number is in progress, even while the final
// character still waits in the output register. A receiver stall holds
// the character and freezes the digit walk. Reset empties the output
// register and returns the sequencer to idle.
module integer_to_ascii_digits import i2a_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [IN_W-1:0]   s_value,
    input  logic [OP_W-1:0]   s_op,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_char_out,
    output logic              m_last
);

    localparam int DEC_DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
    localparam int CNT_W      = $clog2(VALUE_BITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NEG  = 3'd1;
    localparam logic [2:0] ST_CONV = 3'd2;
    localparam logic [2:0] ST_SKIP = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              hex_reg, hex_next;
    logic              minus_reg, minus_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_char_reg, m_char_next;
    logic              m_last_reg, m_last_next;

    i2a_bin_ctrl_t     bin_ctrl;
    i2a_bcd_ctrl_t     bcd_ctrl;
    logic              bin_msb;
    logic [DIGIT_W-1:0] top_digit;
    logic              accept;
    logic              out_free;
    logic              bits_done;
    logic              final_digit;
    logic              is_neg;

    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign bits_done   = cnt_reg == CNT_W'(VALUE_BITS - 1);
    assign final_digit = cnt_reg == CNT_W'(DEC_DIGITS - 1);
    assign is_neg      = (s_op == OP_SDEC) && s_value[VALUE_BITS-1];

    // Sequence load, negation, conversion, zero skip and emission
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        hex_next     = hex_reg;
        minus_next   = minus_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        bin_ctrl     = '0;
        bcd_ctrl     = '0;
        bcd_ctrl.hex = hex_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    bin_ctrl.load  = 1'b1;
                    bcd_ctrl.clear = 1'b1;
                    hex_next       = s_op == OP_UHEX;
                    minus_next     = is_neg;
                    cnt_next       = '0;
                    state_next     = is_neg ? ST_NEG : ST_CONV;
                end
            end
            ST_NEG: begin
                bin_ctrl.negate = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (bits_done) begin
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bin_ctrl.shift     = 1'b1;
                bcd_ctrl.bit_shift = 1'b1;
                cnt_next           = cnt_reg + 1'b1;
                if (bits_done) begin
                    cnt_next   = '0;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit == '0 && !final_digit) begin
                    bcd_ctrl.digit_shift = 1'b1;
                    cnt_next             = cnt_reg + 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (minus_reg) begin
                        m_char_next = ASCII_MINUS;
                        m_last_next = 1'b0;
                        minus_next  = 1'b0;
                    end else begin
                        m_char_next          = digit_glyph(top_digit);
                        m_last_next          = final_digit;
                        bcd_ctrl.digit_shift = 1'b1;
                        cnt_next             = cnt_reg + 1'b1;
                        if (final_digit) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state under reset, payload registers free-running
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cnt_reg    <= cnt_next;
        hex_reg    <= hex_next;
        minus_reg  <= minus_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    i2a_bin_sr #(
        .VALUE_BITS(VALUE_BITS)
    ) u_bin_sr (
        .aclk      (aclk),
        .ctrl      (bin_ctrl),
        .load_value(s_value[VALUE_BITS-1:0]),
        .msb       (bin_msb)
    );

    i2a_bcd #(
        .DIGITS(DEC_DIGITS)
    ) u_bcd (
        .aclk     (aclk),
        .ctrl     (bcd_ctrl),
        .bit_in   (bin_msb),
        .top_digit(top_digit)
    );

    assign s_ready    = state_reg == ST_IDLE;
    assign m_valid    = m_valid_reg;
    assign m_char_out = m_char_reg;
    assign m_last     = m_last_reg;

endmodule

@@ sv/i2a_checker.sv @@
// Port-level checker for the converter and its bind to the top level.
`include "integer_to_ascii_digits_macros.svh"

module i2a_checker import i2a_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CHAR_W-1:0] m_char_out,
    input logic              m_last
);

    // Output register empties on reset
    `I2A_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "output valid after reset")

    // Stalled beat holds
    `I2A_ASSERT(a_stall_hold, m_valid && !m_ready |=> m_valid && $stable(m_char_out) && $stable(m_last), "stalled beat changed")

    // Only sign, decimal digits or upper-case hex letters leave the block
    `I2A_ASSERT(a_glyph, m_valid |-> (m_char_out == ASCII_MINUS) || (m_char_out >= ASCII_ZERO && m_char_out <= 7'h39) || (m_char_out >= ASCII_UPPER_A && m_char_out <= 7'h46), "illegal character")

    // A number in flight blocks the input side
    `I2A_ASSERT(a_busy_mid_number, m_valid && !m_last |-> !s_ready, "input ready mid-number")

    // A minus sign never ends a number
    `I2A_ASSERT(a_minus_not_last, m_valid && m_char_out == ASCII_MINUS |-> !m_last, "minus marked last")

endmodule

bind integer_to_ascii_digits i2a_checker u_i2a_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_char_out(m_char_out),
    .m_last    (m_last)
);

@@ verif/integer_to_ascii_digits_tb.sv @@
// Self-checking testbench for the integer to ASCII digit string converter.

// Holds the characters still owed by the block and checks each output beat.
class digit_scoreboard;
    localparam int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF;
    localparam int MAX_CHARS  = 20;
    localparam logic [63:0] VALUE_MASK =
        (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << (VALUE_BITS % 64)) - 64'd1);
    localparam logic [63:0] DEC_RADIX = 64'd10;
    localparam logic [63:0] HEX_RADIX = 64'd16;

    typedef struct packed {
        logic [i2a_pkg::CHAR_W-1:0] glyph;
        logic                       last;
    } char_beat_t;

    char_beat_t awaited_chars[$];
    int mismatches;
    int numbers_seen;
    int negatives_seen;
    int chars_checked;

    function new();
        mismatches     = 0;
        numbers_seen   = 0;
        negatives_seen = 0;
        chars_checked  = 0;
    endfunction

    function int pending();
        return awaited_chars.size();
    endfunction

    // Work out the digit string of one accepted number and queue its characters
    function void note_number(input logic [63:0] value, input logic [i2a_pkg::OP_W-1:0] op);
        logic [63:0] mag;
        logic [63:0] radix;
        logic [3:0]  digits [MAX_CHARS];
        logic [i2a_pkg::CHAR_W-1:0] dx;
        char_beat_t  beat;
        bit          neg;
        int          nd;
        int          n;
        mag   = value & VALUE_MASK;
        radix = (op == i2a_pkg::OP_UHEX) ? HEX_RADIX : DEC_RADIX;
        neg   = 1'b0;
        nd    = 0;
        n     = 0;
        numbers_seen++;
        // negate within the value width; the most negative value stays its own magnitude
        if (op == i2a_pkg::OP_SDEC && mag[VALUE_BITS-1]) begin
            neg = 1'b1;
            mag = (~mag + 64'd1) & VALUE_MASK;
            negatives_seen++;
        end
        // collect digits least significant first
        if (mag == 64'd0) begin
            digits[0] = 4'd0;
            nd = 1;
        end else begin
            while (mag != 64'd0 && nd < MAX_CHARS) begin
                digits[nd] = 4'(mag % radix);
                mag = mag / radix;
                nd++;
            end
        end
        if (neg) begin
            beat.glyph = i2a_pkg::ASCII_MINUS;
            beat.last  = 1'b0;
            awaited_chars.push_back(beat);
            n = 1;
        end
        // emit most significant first, mark the final one
        for (int i = nd - 1; i >= 0 && n < MAX_CHARS; i--) begin
            dx = {{(i2a_pkg::CHAR_W-4){1'b0}}, digits[i]};
            if (digits[i] < 4'd10) begin
                beat.glyph = i2a_pkg::ASCII_ZERO + dx;
            end else begin
                beat.glyph = i2a_pkg::ASCII_UPPER_A + dx - 7'd10;
            end
            beat.last = (i == 0 || n == MAX_CHARS - 1);
            awaited_chars.push_back(beat);
            n++;
        end
    endfunction

    task report(input string msg);
        if (mismatches < 30) begin
            $display("mismatch: %s", msg);
        end
        mismatches++;
    endtask

    // Compare one output beat with the oldest owed character
    task check_char(input logic [i2a_pkg::CHAR_W-1:0] glyph, input logic last);
        char_beat_t want;
        chars_checked++;
        if (awaited_chars.size() == 0) begin
            report($sformatf("unexpected character 0x%02h last=%0b", glyph, last));
        end else begin
            want = awaited_chars.pop_front();
            if (glyph !== want.glyph) begin
                report($sformatf("character %0d: got 0x%02h, want 0x%02h",
                                 chars_checked, glyph, want.glyph));
            end
            if (last !== want.last) begin
                report($sformatf("character %0d: last got %0b, want %0b",
                                 chars_checked, last, want.last));
            end
        end
    endtask
endclass

module integer_to_ascii_digits_tb;
    import i2a_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 500;
    localparam int CALM_TAIL     = 60;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [OP_W-1:0] OP_ALIAS_UDEC = 2'd3;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [IN_W-1:0]   s_value;
    logic [OP_W-1:0]   s_op;
    logic              m_valid;
    logic              m_ready;
    logic [CHAR_W-1:0] m_char_out;
    logic              m_last;

    digit_scoreboard digit_sb;
    bit  send_gaps_on;
    bit  recv_stalls_on;
    int  cycle_count = 0;

    integer_to_ascii_digits DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .s_op       (s_op),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_char_out (m_char_out),
        .m_last     (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Offer one number, optionally after a gap, and hold it until accepted
    task automatic send_number(input logic [63:0] value, input logic [OP_W-1:0] op);
        if (send_gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        s_op    <= op;
        do @(posedge aclk); while (!s_ready);
        digit_sb.note_number(value, op);
    endtask

    // Drop valid and wait until every owed character has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        while (digit_sb.pending() != 0) @(posedge aclk);
    endtask

    // Pick a value biased towards short numbers, signs and digit boundaries
    function automatic logic [63:0] random_value();
        logic [63:0] raw;
        logic [63:0] p;
        int          k;
        raw = {$urandom, $urandom};
        p   = 64'd1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return raw;
            4, 5, 6:    return raw >> $urandom_range(0, 63);
            7:          return -(raw >> $urandom_range(1, 63));
            8: begin
                k = $urandom_range(0, 19);
                repeat (k) p = p * 64'd10;
                case ($urandom_range(0, 2))
                    0: return p - 64'd1;
                    1: return p;
                    default: return p + 64'd1;
                endcase
            end
            default: return 64'd1 << $urandom_range(0, 63);
        endcase
    endfunction

    // Check every output beat; inputs are noted by the sender
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid && m_ready) begin
            digit_sb.check_char(m_char_out, m_last);
        end
    end

    // Stall the receiver in random bursts
    initial begin
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (recv_stalls_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Give up on a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        digit_sb       = new();
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_value <= '0;
        s_op    <= OP_UDEC;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero in every mode, including the alias of unsigned decimal
        send_number(64'd0, OP_UDEC);
        send_number(64'd0, OP_UHEX);
        send_number(64'd0, OP_SDEC);
        send_number(64'd0, OP_ALIAS_UDEC);
        // all ones: longest unsigned decimal, full hex, minus one
        send_number({64{1'b1}}, OP_UDEC);
        send_number({64{1'b1}}, OP_UHEX);
        send_number({64{1'b1}}, OP_SDEC);
        send_number({64{1'b1}}, OP_ALIAS_UDEC);
        // most negative and most positive signed values
        send_number(64'h8000_0000_0000_0000, OP_SDEC);
        send_number(64'h8000_0000_0000_0000, OP_UDEC);
        send_number(64'h7FFF_FFFF_FFFF_FFFF, OP_SDEC);
        send_number(64'h7FFF_FFFF_FFFF_FFFF, OP_UHEX);
        // digit boundaries
        send_number(64'd1, OP_SDEC);
        send_number(64'd9, OP_UDEC);
        send_number(64'd10, OP_UDEC);
        send_number(64'd15, OP_UHEX);
        send_number(64'd16, OP_UHEX);
        send_number(64'd10000000000000000000, OP_UDEC);
        send_number(64'd9999999999999999999, OP_UDEC);
        send_number(64'hFEDC_BA98_7654_3210, OP_UHEX);
        send_number({$urandom, $urandom}, OP_ALIAS_UDEC);

        // hold off the sender until the block has emptied
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - CALM_TAIL) begin
                send_gaps_on   = 1'b0;
                recv_stalls_on = 1'b0;
            end else if (i % 50 == 0) begin
                send_gaps_on   = ($urandom_range(0, 3) != 0);
                recv_stalls_on = ($urandom_range(0, 3) != 0);
            end
            if (i > 0 && i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 99) == 0) begin
                drain_results();
            end
            send_number(random_value(), OP_W'($urandom_range(0, 3)));
        end

        // wait out the last characters, then let the block settle
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (digit_sb.pending() != 0) begin
            digit_sb.report($sformatf("%0d characters never arrived", digit_sb.pending()));
        end

        $display("run: %0d numbers converted (%0d negative signed), %0d characters checked",
                 digit_sb.numbers_seen, digit_sb.negatives_seen, digit_sb.chars_checked);
        $display("run: %0d mismatches in %0d cycles", digit_sb.mismatches, cycle_count);
        if (digit_sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+sv
sv/i2a_pkg.sv
sv/i2a_bin_sr.sv
sv/i2a_bcd.sv
sv/integer_to_ascii_digits.sv
sv/i2a_checker.sv
verif/integer_to_ascii_digits_tb.sv
